>>> rtl/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants of the counting semaphore with its wait queue.
// ----------------------------------------------------------------------------
package csem_pkg;

   // default depth of the wait queue
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned TID_W     = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned WAITERS_W = 5;

   // largest permit count
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // depth of the result queue in front of the response channel
   localparam int unsigned OQ_DEPTH = 4;

   // register file: one register at byte address 0
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_ADDR_INITIAL_COUNT = 2'd0;

   // operation codes
   localparam logic FUNC_WAIT   = 1'b0;
   localparam logic FUNC_SIGNAL = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_SUCCESS   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

   // request word
   typedef struct packed {
      logic               func;
      logic [TID_W-1:0]   thread_id;
      logic               may_block;
   } req_type;

   // response word
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 blocked;
      logic                 wake_valid;
      logic [TID_W-1:0]     wake_thread;
      logic [COUNT_W-1:0]   count_now;
      logic [WAITERS_W-1:0] waiters_now;
   } rsp_type;

   // wait memory access of one operation
   typedef struct packed {
      logic push;
      logic pop;
   } mem_op_type;

endpackage

>>> rtl/csem_wait_ram.sv
// ----------------------------------------------------------------------------
// csem_wait_ram
// Thread id memory of the wait queue: one write port, one registered read.
// ----------------------------------------------------------------------------
module csem_wait_ram
   import csem_pkg::*;
#(
   parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF,
   parameter int unsigned ADDR_W = 4
) (
   input  logic               clock,
   input  mem_op_type         mem_op,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [TID_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [TID_W-1:0]   rd_data
);

   logic [TID_W-1:0] mem [DEPTH];
   logic [TID_W-1:0] rd_data_ff;

   // push writes the tail entry
   always_ff @(posedge clock) begin
      if (mem_op.push) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // pop reads the head entry into a register; the data follows in the next cycle
   always_ff @(posedge clock) begin
      if (mem_op.pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl
// Permit counter, queue pointers and waiter count; decides each operation
// and registers its result fields.
// ----------------------------------------------------------------------------
module csem_ctrl
   import csem_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int unsigned PTR_W       = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  logic [COUNT_W-1:0]  load_value,
   input  logic                req_accept,
   input  req_type             req_data,
   output mem_op_type          mem_op,
   output logic [PTR_W-1:0]    wr_addr,
   output logic [PTR_W-1:0]    rd_addr,
   output logic                stage_valid,
   output rsp_type             stage_data
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_W-1:0] permit_ff, permit_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   waiters_ff, waiters_in;
   logic               stage_valid_ff;
   rsp_type            stage_ff, stage_in;
   logic [STATUS_W-1:0] status;
   logic               blocked;
   logic               wake;
   mem_op_type         op;

   // pointer advance with wrap at the queue depth
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] idx);
      logic [PTR_W-1:0] nxt;
      if (idx == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

   // decide the operation
   always_comb begin
      permit_in  = permit_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      waiters_in = waiters_ff;
      op         = '0;
      status     = ST_SUCCESS;
      blocked    = 1'b0;
      wake       = 1'b0;
      if (load_en) begin
         permit_in = load_value;
      end
      if (req_accept) begin
         if (req_data.func == FUNC_WAIT) begin
            priority if (permit_ff != '0) begin
               permit_in = permit_ff - 1'b1;
            end else if (!req_data.may_block) begin
               status = ST_BUSY;
            end else if (waiters_ff == CNT_W'(QUEUE_DEPTH)) begin
               status = ST_FULL;
            end else begin
               op.push    = 1'b1;
               tail_in    = next_slot(tail_ff);
               waiters_in = waiters_ff + 1'b1;
               blocked    = 1'b1;
            end
         end else begin
            priority if (waiters_ff != '0) begin
               op.pop     = 1'b1;
               head_in    = next_slot(head_ff);
               waiters_in = waiters_ff - 1'b1;
               wake       = 1'b1;
            end else if (permit_ff == COUNT_MAX) begin
               status = ST_SATURATED;
            end else begin
               permit_in = permit_ff + 1'b1;
            end
         end
      end
   end

   // result fields; wake thread is filled in from the memory in the next cycle
   always_comb begin
      stage_in.status      = status;
      stage_in.blocked     = blocked;
      stage_in.wake_valid  = wake;
      stage_in.wake_thread = '0;
      stage_in.count_now   = permit_in;
      stage_in.waiters_now = WAITERS_W'(waiters_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         permit_ff      <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         waiters_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         permit_ff      <= permit_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         waiters_ff     <= waiters_in;
         stage_valid_ff <= req_accept;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   assign mem_op      = op;
   assign wr_addr     = tail_ff;
   assign rd_addr     = head_ff;
   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_ff;

endmodule

>>> rtl/csem_rsp_queue.sv
// ----------------------------------------------------------------------------
// csem_rsp_queue
// Small result queue in front of the response channel; merges the woken
// thread id read from the wait memory.
// ----------------------------------------------------------------------------
module csem_rsp_queue
   import csem_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  rsp_type                           push_data,
   input  logic [TID_W-1:0]                  wake_data,
   output logic [$clog2(OQ_DEPTH + 1)-1:0]   level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rsp_type                           rsp_data
);

   localparam int unsigned QP_W  = $clog2(OQ_DEPTH);
   localparam int unsigned LVL_W = $clog2(OQ_DEPTH + 1);

   rsp_type          q_ff [OQ_DEPTH];
   rsp_type          entry;
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             pop;

   // woken thread id comes straight from the memory read register
   always_comb begin
      entry = push_data;
      if (push_data.wake_valid) begin
         entry.wake_thread = wake_data;
      end else begin
         entry.wake_thread = '0;
      end
   end

   assign pop = rsp_valid && !rsp_stall;

   // pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign level     = level_ff;
   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];

endmodule

>>> rtl/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of waiting thread ids.
// ----------------------------------------------------------------------------
// Each request word is a wait or a signal and gives exactly one response
// word. A new request can be taken every cycle while req_stall is low: the
// permit counter, queue pointers and waiter count are updated in the accept
// cycle, and the thread id memory (one write port, one registered read port)
// is read on a signal with waiters so the woken id is ready in the next
// cycle. Responses pass through a four-word queue; the request side is stalled
// while that queue and the word in flight would fill it. The thread id memory
// needs no clearing after reset. Writing initial_count (offset 0) loads the
// permit counter; users write it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
   import csem_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned LVL_W = $clog2(OQ_DEPTH + 1);

   logic [COUNT_W-1:0] initial_count_ff;
   logic               csr_wr;
   logic               req_accept;
   mem_op_type         mem_op;
   logic [PTR_W-1:0]   wr_addr;
   logic [PTR_W-1:0]   rd_addr;
   logic [TID_W-1:0]   rd_data;
   logic               stage_valid;
   rsp_type            stage_data;
   logic [LVL_W-1:0]   level;
   logic [LVL_W:0]     in_use;

   // register write and read
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr == REG_ADDR_INITIAL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_count_ff <= '0;
      end else if (csr_wr) begin
         initial_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (paddr == REG_ADDR_INITIAL_COUNT) begin
         prdata = CSR_DATA_W'(initial_count_ff);
      end else begin
         prdata = '0;
      end
   end

   // request admission: queued words plus the word in flight leave room
   assign in_use     = {1'b0, level} + (LVL_W + 1)'(stage_valid);
   assign req_stall  = (in_use >= (LVL_W + 1)'(OQ_DEPTH));
   assign req_accept = req_valid && !req_stall;

   csem_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load_en     (csr_wr),
      .load_value  (pwdata[COUNT_W-1:0]),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .mem_op      (mem_op),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   csem_wait_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (PTR_W)
   ) u_wait_ram (
      .clock   (clock),
      .mem_op  (mem_op),
      .wr_addr (wr_addr),
      .wr_data (req_data.thread_id),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csem_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (stage_valid),
      .push_data (stage_data),
      .wake_data (rd_data),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/csem_checker.sv
// ----------------------------------------------------------------------------
// csem_checker
// Port-level checks of the semaphore's response words.
// ----------------------------------------------------------------------------
module csem_checker
   import csem_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no wake id without a wake
   a_wake_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wake_valid |-> rsp_data.wake_thread == '0)
      else $error("wake thread set without wake");

   // a blocked wait is a success with no wake and no permit left
   a_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.blocked |->
         rsp_data.status == ST_SUCCESS && !rsp_data.wake_valid &&
         rsp_data.count_now == '0 && rsp_data.waiters_now != '0)
      else $error("inconsistent blocked response");

   // a wake is a success and never blocks the caller
   a_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.wake_valid |->
         rsp_data.status == ST_SUCCESS && !rsp_data.blocked)
      else $error("inconsistent wake response");

endmodule

bind counting_semaphore_wait_queue csem_checker u_csem_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
